// ===== rtl/core/wsp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_pkg: shared types and constants for the WAV stream to PCM16 parser
// Beat structs, result kinds and the record passed from parser to converter.
// ---------------------------------------------------------------------------
package wsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [15:0] sample;
        logic [31:0]       rate;
        logic [15:0]       channel_count;
        logic              end_mark;
    } t_out_beat;

    localparam logic [2:0] KIND_SAMPLE = 3'd0;
    localparam logic [2:0] KIND_OK     = 3'd1;
    localparam logic [2:0] KIND_BADHDR = 3'd2;
    localparam logic [2:0] KIND_NODATA = 3'd3;
    localparam logic [2:0] KIND_UNSUP  = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Sample conversion selector
    localparam logic [2:0] CV_U8  = 3'd0;
    localparam logic [2:0] CV_S16 = 3'd1;
    localparam logic [2:0] CV_S24 = 3'd2;
    localparam logic [2:0] CV_S32 = 3'd3;
    localparam logic [2:0] CV_F32 = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 4;

    // One queued job: a raw sample word, a status, or both
    typedef struct packed {
        logic        has_sample;
        logic [2:0]  conv;
        logic [31:0] raw;
        logic        has_status;
        logic [2:0]  kind;
        logic [31:0] rate;
        logic [15:0] channel_count;
    } t_job;

endpackage

// ===== rtl/core/wsp_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_front: RIFF/WAVE chunk walker
// Tracks the header, chunk list and fmt fields; emits one job per byte that
// completes a sample or ends the file.
// ---------------------------------------------------------------------------
module wsp_front
    import wsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_file_length,
    input  logic        i_valid,
    input  t_in_beat    i_beat,
    output logic        o_stall,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_stall
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHDR   = 3'd1;
    localparam logic [2:0] PH_BODY   = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    logic [2:0]  r_phase,  n_phase;
    logic [31:0] r_pos,    n_pos;
    logic [31:0] r_tag,    n_tag;
    logic [31:0] r_left,   n_left;
    logic [15:0] r_fmt,    n_fmt;
    logic [15:0] r_chan,   n_chan;
    logic [31:0] r_rate,   n_rate;
    logic [15:0] r_bits,   n_bits;
    logic [31:0] r_asm,    n_asm;
    logic [1:0]  r_acnt,   n_acnt;
    logic        r_bad,    n_bad;
    logic        r_fseen,  n_fseen;
    logic        r_dtaken, n_dtaken;
    logic        r_emit,   n_emit;

    logic        take;
    logic [31:0] nxt;
    logic [32:0] hdr_end;
    logic        sup;
    logic [2:0]  conv;
    logic [2:0]  bps;
    logic [31:0] shb;
    logic [31:0] new_asm;
    logic        job_s, job_t;
    logic [2:0]  kind;

    function automatic logic sup_next(input logic [15:0] f, input logic [15:0] b);
        if (f == 16'd1)
            return b == 16'd8 || b == 16'd16 || b == 16'd24 || b == 16'd32;
        return f == 16'd3 && b == 16'd32;
    endfunction

    assign o_stall = i_job_stall;
    assign take    = i_valid && !i_job_stall;
    assign nxt     = (r_pos == 32'hFFFF_FFFF) ? r_pos : r_pos + 32'd1;
    assign hdr_end  = {1'b0, nxt} + 33'd8;

    always_comb begin
        sup = 1'b0;
        if (r_fmt == 16'd1)
            sup = r_bits == 16'd8 || r_bits == 16'd16 || r_bits == 16'd24 || r_bits == 16'd32;
        else if (r_fmt == 16'd3)
            sup = r_bits == 16'd32;
    end

    always_comb begin
        if (r_bits == 16'd8)       conv = CV_U8;
        else if (r_bits == 16'd16) conv = CV_S16;
        else if (r_bits == 16'd24) conv = CV_S24;
        else if (r_fmt == 16'd1)   conv = CV_S32;
        else                       conv = CV_F32;
    end

    assign bps = r_bits[5:3];
    assign shb = {24'd0, i_beat.data_byte};

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_tag = r_tag; n_left = r_left;
        n_fmt = r_fmt; n_chan = r_chan; n_rate = r_rate; n_bits = r_bits;
        n_asm = r_asm; n_acnt = r_acnt; n_bad = r_bad; n_fseen = r_fseen;
        n_dtaken = r_dtaken; n_emit = r_emit;
        job_s = 1'b0;
        new_asm = r_asm | (shb << {r_acnt, 3'b000});

        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos < 32'd4 || (r_pos >= 32'd8 && r_pos < 32'd12))
                    n_tag = r_tag | (shb << {r_pos[1:0], 3'b000});
                if (r_pos == 32'd3) begin
                    if (n_tag != TAG_RIFF) n_bad = 1'b1;
                    n_tag = '0;
                end
                if (r_pos == 32'd11) begin
                    if (n_tag != TAG_WAVE) n_bad = 1'b1;
                    n_tag = '0;
                    if (n_bad) n_phase = PH_STOP;
                    else if (hdr_end > {1'b0, i_file_length}) n_phase = PH_STOP;
                    else begin
                        n_phase = PH_CHDR; n_left = 32'd8; n_asm = '0;
                    end
                end
            end
            PH_CHDR: begin
                if (r_left > 32'd4)
                    n_tag = r_tag | (shb << {2'(3'd0 - r_left[1:0]), 3'b000});
                else
                    n_asm = r_asm | (shb << {2'(3'd0 - r_left[1:0]), 3'b000});
                n_left = r_left - 32'd1;
            end
            PH_BODY: begin
                if (r_tag == TAG_FMT) begin
                    case (r_asm[4:0])
                        5'd0:  n_fmt[7:0]   = i_beat.data_byte;
                        5'd1:  n_fmt[15:8]  = i_beat.data_byte;
                        5'd2:  n_chan[7:0]  = i_beat.data_byte;
                        5'd3:  n_chan[15:8] = i_beat.data_byte;
                        5'd4:  n_rate[7:0]  = i_beat.data_byte;
                        5'd5:  n_rate[15:8] = i_beat.data_byte;
                        5'd6:  n_rate[23:16] = i_beat.data_byte;
                        5'd7:  n_rate[31:24] = i_beat.data_byte;
                        5'd14: n_bits[7:0]  = i_beat.data_byte;
                        5'd15: n_bits[15:8] = i_beat.data_byte;
                        default: ;
                    endcase
                    if (r_asm < 32'd16) n_asm = r_asm + 32'd1;
                end else if (r_tag == TAG_DATA && r_emit) begin
                    if ({1'b0, r_acnt} + 3'd1 >= bps) begin
                        job_s = 1'b1;
                        n_asm = '0; n_acnt = '0;
                    end else begin
                        n_asm = new_asm;
                        n_acnt = r_acnt + 2'd1;
                    end
                end
                n_left = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    if (nxt[0]) n_phase = PH_PAD;
                    else if (hdr_end > {1'b0, i_file_length}) n_phase = PH_STOP;
                    else begin
                        n_phase = PH_CHDR; n_left = 32'd8; n_tag = '0; n_asm = '0;
                    end
                end
            end
            PH_PAD: begin
                if (hdr_end > {1'b0, i_file_length}) n_phase = PH_STOP;
                else begin
                    n_phase = PH_CHDR; n_left = 32'd8; n_tag = '0; n_asm = '0;
                end
            end
            default: ;
        endcase

        // Chunk header complete: size sits in n_asm
        if (r_phase == PH_CHDR && n_left == 32'd0) begin
            if ({1'b0, nxt} + {1'b0, n_asm} > {1'b0, i_file_length}) begin
                n_phase = PH_STOP;
            end else begin
                if (n_tag == TAG_FMT && n_asm >= 32'd16 && !r_dtaken) begin
                    n_fseen = 1'b1;
                end else if (n_tag == TAG_DATA && r_fseen && !r_dtaken) begin
                    n_dtaken = 1'b1;
                    if (r_chan != 16'd0 && r_rate != 32'd0 && sup) n_emit = 1'b1;
                end else begin
                    n_tag = '0;
                end
                n_left = n_asm;
                n_acnt = '0;
                if (n_asm == 32'd0) begin
                    if (nxt[0]) n_phase = PH_PAD;
                    else if (hdr_end > {1'b0, i_file_length}) n_phase = PH_STOP;
                    else begin
                        n_phase = PH_CHDR; n_left = 32'd8; n_tag = '0;
                    end
                end else begin
                    n_phase = PH_BODY;
                end
                n_asm = '0;
            end
        end
        n_pos = nxt;

        job_t = i_beat.last_byte;
        if (nxt < 32'd44 || n_bad)                                    kind = KIND_BADHDR;
        else if (!n_dtaken || n_chan == 16'd0 || n_rate == 32'd0)     kind = KIND_NODATA;
        else if (!sup_next(n_fmt, n_bits))                            kind = KIND_UNSUP;
        else                                                          kind = KIND_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_tag <= '0; r_left <= '0;
            r_fmt <= '0; r_chan <= '0; r_rate <= '0; r_bits <= '0;
            r_asm <= '0; r_acnt <= '0;
            r_bad <= 1'b0; r_fseen <= 1'b0; r_dtaken <= 1'b0; r_emit <= 1'b0;
        end else if (take) begin
            if (i_beat.last_byte) begin
                r_phase <= PH_HEADER; r_pos <= '0; r_tag <= '0; r_left <= '0;
                r_fmt <= '0; r_chan <= '0; r_rate <= '0; r_bits <= '0;
                r_asm <= '0; r_acnt <= '0;
                r_bad <= 1'b0; r_fseen <= 1'b0; r_dtaken <= 1'b0; r_emit <= 1'b0;
            end else begin
                r_phase <= n_phase; r_pos <= n_pos; r_tag <= n_tag; r_left <= n_left;
                r_fmt <= n_fmt; r_chan <= n_chan; r_rate <= n_rate; r_bits <= n_bits;
                r_asm <= n_asm; r_acnt <= n_acnt;
                r_bad <= n_bad; r_fseen <= n_fseen; r_dtaken <= n_dtaken;
                r_emit <= n_emit;
            end
        end
    end

    assign o_job_valid = i_valid && (job_s || job_t);
    always_comb begin
        o_job.has_sample    = job_s;
        o_job.conv          = conv;
        o_job.raw           = new_asm;
        o_job.has_status    = job_t;
        o_job.kind          = kind;
        o_job.rate          = n_rate;
        o_job.channel_count = n_chan;
    end

endmodule

// ===== rtl/core/wsp_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_queue: small job FIFO between walker and converter
// Registered storage, full/empty from a count.
// ---------------------------------------------------------------------------
module wsp_queue
    import wsp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    input  t_job i_wr_job,
    output logic o_full,
    output logic o_rd_valid,
    output t_job o_rd_job,
    input  logic i_rd_take
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job              r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              wr, rd;

    assign o_full     = r_cnt == (AW+1)'(DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_job   = r_mem[r_rp];
    assign wr = i_wr_valid && !o_full;
    assign rd = i_rd_take && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

endmodule

// ===== rtl/core/wsp_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsp_back: sample converter and result sequencer
// Converts raw words to 16-bit samples and sends sample then status beats.
// ---------------------------------------------------------------------------
module wsp_back
    import wsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_take,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    logic        r_valid;
    t_out_beat   r_beat;
    logic        r_half;   // sample of current job already sent
    logic [15:0] cv;
    logic        load;
    logic        two;

    // Float: clamp to +-1, scale by 32767 and truncate. For |f|<1 the product
    // m*32767 = m*2^15 - m, rounded to 24 bits then truncated toward zero.
    logic [7:0]  fe;
    logic [23:0] fm;
    logic [39:0] prod;
    logic [5:0]  lz;
    logic [39:0] nrm;
    logic [23:0] rm;
    logic        rb, st;
    logic [24:0] rnd;
    logic [15:0] mag;

    assign fe = i_job.raw[30:23];
    assign fm = {1'b1, i_job.raw[22:0]};
    assign prod = {16'd0, fm} * 40'd32767;

    always_comb begin
        lz = '0;
        for (int k = 39; k >= 0; k--) begin
            if (prod[k] && lz == '0) lz = 6'(39 - k);
        end
        nrm = prod << lz;
        rm  = nrm[39:16];
        rb  = nrm[15];
        st  = |nrm[14:0];
        rnd = {1'b0, rm} + 25'((rb && (st || rm[0])) ? 1 : 0);
        // value = rnd * 2^-(7 + lz + (127 - fe)); a rounding carry lands in rnd[24]
        mag = '0;
        if (fe < 8'd127) begin
            if (8'd127 - fe <= 8'd16)
                mag = 16'(rnd >> (8'd7 + 8'(lz) + (8'd127 - fe)));
        end else begin
            mag = 16'd32767;
        end
    end

    always_comb begin
        unique case (i_job.conv)
            CV_U8:  cv = {i_job.raw[7:0] ^ 8'h80, 8'h00};
            CV_S16: cv = i_job.raw[15:0];
            CV_S24: cv = i_job.raw[23:8];
            CV_S32: cv = i_job.raw[31:16];
            default: begin
                if (fe == 8'hFF && i_job.raw[22:0] != '0) cv = '0;
                else if (i_job.raw[31]) cv = -mag;
                else cv = mag;
            end
        endcase
    end

    assign two  = i_job.has_sample && i_job.has_status;
    assign load = i_job_valid && (!r_valid || !i_stall);
    assign o_job_take = load && (!two || r_half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= two && !r_half;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_job.has_sample && !r_half) begin
                r_beat.kind          <= KIND_SAMPLE;
                r_beat.sample        <= cv;
                r_beat.rate          <= '0;
                r_beat.channel_count <= '0;
                r_beat.end_mark      <= 1'b0;
            end else begin
                r_beat.kind          <= i_job.kind;
                r_beat.sample        <= '0;
                r_beat.rate          <= i_job.rate;
                r_beat.channel_count <= i_job.channel_count;
                r_beat.end_mark      <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== rtl/core/wav_stream_to_pcm16.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wav_stream_to_pcm16: streaming RIFF/WAVE parser with PCM16 conversion
// Walks the chunk list byte by byte and converts the first data chunk after fmt.
// ---------------------------------------------------------------------------
// Throughput: one input beat per cycle while the job queue is not full; a byte
//   ending the file while also finishing a sample yields two result beats.
// Path: the job is queued at the accepting edge and later loaded into the output
//   register, where the result beat is offered; an output stall can hold it queued.
// Reset: synchronous active-low; clears walker state, queue, output valid and file_length.
// The walker is stalled only when the job queue is full.
module wav_stream_to_pcm16
    import wsp_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  t_in_beat    i_data,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_beat   o_data,
    input  logic        i_stall
);

    logic [31:0] r_file_length;
    logic        job_valid, q_full, q_valid, q_take;
    t_job        job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_file_length <= '0;
        else if (i_cfg_we) r_file_length <= i_cfg_data;
    end

    // Front: chunk walk, one job per sample or end of file
    wsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_file_length(r_file_length),
        .i_valid(i_valid), .i_beat(i_data), .o_stall(o_stall),
        .o_job_valid(job_valid), .o_job(job), .i_job_stall(q_full)
    );

    wsp_queue #(.DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_valid(job_valid), .i_wr_job(job),
        .o_full(q_full), .o_rd_valid(q_valid), .o_rd_job(q_job), .i_rd_take(q_take)
    );

    // Back: conversion and result beats
    wsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(q_valid), .i_job(q_job),
        .o_job_take(q_take), .o_valid(o_valid), .o_beat(o_data), .i_stall(i_stall)
    );

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == q_full) else $error("stall not tied to queue full");
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.end_mark |-> o_data.kind != KIND_SAMPLE)
        else $error("status beat with sample kind");
    a_sample_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.end_mark |-> o_data.kind == KIND_SAMPLE)
        else $error("sample beat with status kind");

endmodule
